// ----- src/bed_pkg.sv -----
`default_nettype none
package bed_pkg;

  // Escape decoder phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_HEX,
    PH_OCT
  } phase_t;

  // One result transfer, less run_last (set by the back end)
  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic       miss;
    logic       stop;
  } res_t;

  localparam int unsigned MAX_RES = 3;

  // All results caused by one input item; res[0] goes out first
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  localparam int unsigned QDEPTH = 2;

  localparam logic [7:0] CH_BS   = 8'h5C;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_C    = 8'h63;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ESC  = 8'h1B;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } letter_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  function automatic letter_t letter_map(input logic [7:0] b);
    letter_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    unique case (b)
      8'h6E: r.code = 8'h0A; // n
      8'h74: r.code = 8'h09; // t
      8'h72: r.code = 8'h0D; // r
      8'h5C: r.code = 8'h5C; // backslash
      8'h61: r.code = 8'h07; // a
      8'h62: r.code = 8'h08; // b
      8'h66: r.code = 8'h0C; // f
      8'h76: r.code = 8'h0B; // v
      8'h65: r.code = CH_ESC; // e
      8'h45: r.code = CH_ESC; // E
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic hexd_t hex_digit(input logic [7:0] b);
    hexd_t r;
    r.ok  = 1'b1;
    r.val = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.val = 4'(b - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h37);
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic has,
                                  input logic miss, input logic stop);
    res_t r;
    r.byte_val = b;
    r.has_byte = has;
    r.miss     = miss;
    r.stop     = stop;
    return r;
  endfunction

  // Append a result; further results beyond MAX_RES are dropped
  function automatic bundle_t put_res(input bundle_t bd, input res_t r);
    bundle_t o;
    o = bd;
    unique case (bd.cnt)
      2'd0: begin
        o.res[0] = r;
        o.cnt    = 2'd1;
      end
      2'd1: begin
        o.res[1] = r;
        o.cnt    = 2'd2;
      end
      2'd2: begin
        o.res[2] = r;
        o.cnt    = 2'd3;
      end
      default: o = bd;
    endcase
    return o;
  endfunction

  // Emit whatever escape is pending in the given phase
  function automatic bundle_t flush_res(input bundle_t bd, input phase_t ph,
                                        input logic [7:0] val, input logic [1:0] dc);
    bundle_t o;
    o = bd;
    unique case (ph)
      PH_ESC: o = put_res(o, mk_res(CH_BS, 1'b1, 1'b0, 1'b0));
      PH_HEX: begin
        if (dc == 2'd0) begin
          o = put_res(o, mk_res(CH_BS, 1'b1, 1'b1, 1'b0));
          o = put_res(o, mk_res(CH_X, 1'b1, 1'b0, 1'b0));
        end else begin
          o = put_res(o, mk_res(val, 1'b1, 1'b0, 1'b0));
        end
      end
      PH_OCT: o = put_res(o, mk_res(val, 1'b1, 1'b0, 1'b0));
      default: o = bd;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- src/bed_front.sv -----
`default_nettype none
module bed_front
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       argument_mode,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       is_last,
  input  wire logic       new_call,
  output bundle_t         bundle,
  output logic            push
);

  phase_t     phase, phase_next;
  logic [7:0] escape_value, escape_value_next;
  logic [1:0] digit_count, digit_count_next;
  logic       output_stopped, output_stopped_next;
  letter_t    lm;
  hexd_t      hd;
  bundle_t    bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      escape_value   <= 8'h00;
      digit_count    <= 2'd0;
      output_stopped <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      escape_value   <= escape_value_next;
      digit_count    <= digit_count_next;
      output_stopped <= output_stopped_next;
    end
  end

  always_comb begin
    lm = letter_map(in_byte);
    hd = hex_digit(in_byte);
    bd = '0;
    phase_next          = phase;
    escape_value_next   = escape_value;
    digit_count_next    = digit_count;
    output_stopped_next = output_stopped;

    // new call drops a stop and any unfinished escape
    if (new_call) begin
      output_stopped_next = 1'b0;
      phase_next          = PH_IDLE;
      escape_value_next   = 8'h00;
      digit_count_next    = 2'd0;
    end

    if (!output_stopped_next) begin
      unique case (phase_next)
        PH_IDLE: begin
          if (in_byte == CH_BS) begin
            phase_next = PH_ESC;
          end else begin
            bd = put_res(bd, mk_res(in_byte, 1'b1, 1'b0, 1'b0));
          end
        end
        PH_ESC: begin
          if (lm.hit) begin
            bd = put_res(bd, mk_res(lm.code, 1'b1, 1'b0, 1'b0));
            phase_next = PH_IDLE;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
          end else if (in_byte == CH_C && argument_mode) begin
            output_stopped_next = 1'b1;
            bd = put_res(bd, mk_res(8'h00, 1'b0, 1'b0, 1'b1));
            phase_next = PH_IDLE;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
          end else if (in_byte == CH_X) begin
            phase_next = PH_HEX;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
          end else if (is_octal(in_byte)) begin
            phase_next = PH_OCT;
            if (argument_mode && in_byte == CH_ZERO) begin
              escape_value_next = 8'h00;
              digit_count_next = 2'd0;
            end else begin
              escape_value_next = {5'd0, in_byte[2:0]};
              digit_count_next = 2'd1;
            end
          end else begin
            // unknown escape: backslash, then the byte itself (never a backslash here)
            bd = put_res(bd, mk_res(CH_BS, 1'b1, 1'b0, 1'b0));
            bd = put_res(bd, mk_res(in_byte, 1'b1, 1'b0, 1'b0));
            phase_next = PH_IDLE;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
          end
        end
        PH_HEX: begin
          if (hd.ok) begin
            escape_value_next = {escape_value_next[3:0], hd.val};
            digit_count_next = digit_count_next + 2'd1;
            if (digit_count_next == 2'd2) begin
              bd = put_res(bd, mk_res(escape_value_next, 1'b1, 1'b0, 1'b0));
              phase_next = PH_IDLE;
              escape_value_next = 8'h00;
              digit_count_next = 2'd0;
            end
          end else begin
            bd = flush_res(bd, phase_next, escape_value_next, digit_count_next);
            phase_next = PH_IDLE;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
            if (in_byte == CH_BS) begin
              phase_next = PH_ESC;
            end else begin
              bd = put_res(bd, mk_res(in_byte, 1'b1, 1'b0, 1'b0));
            end
          end
        end
        PH_OCT: begin
          if (is_octal(in_byte) && digit_count_next != 2'd3) begin
            escape_value_next = {escape_value_next[4:0], in_byte[2:0]};
            digit_count_next = digit_count_next + 2'd1;
            if (digit_count_next == 2'd3) begin
              bd = put_res(bd, mk_res(escape_value_next, 1'b1, 1'b0, 1'b0));
              phase_next = PH_IDLE;
              escape_value_next = 8'h00;
              digit_count_next = 2'd0;
            end
          end else begin
            bd = flush_res(bd, phase_next, escape_value_next, digit_count_next);
            phase_next = PH_IDLE;
            escape_value_next = 8'h00;
            digit_count_next = 2'd0;
            if (in_byte == CH_BS) begin
              phase_next = PH_ESC;
            end else begin
              bd = put_res(bd, mk_res(in_byte, 1'b1, 1'b0, 1'b0));
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (is_last && !output_stopped_next) begin
        bd = flush_res(bd, phase_next, escape_value_next, digit_count_next);
        phase_next = PH_IDLE;
        escape_value_next = 8'h00;
        digit_count_next = 2'd0;
      end
    end
  end

  assign bundle = bd;
  assign push   = accept && (bd.cnt != 2'd0);

endmodule
`default_nettype wire

// ----- src/bed_queue.sv -----
`default_nettype none
module bed_queue
  import bed_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = $clog2(QDEPTH);

  bundle_t         mem [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = mem[rptr];
  assign full     = (count == (PW+1)'(QDEPTH));
  assign empty    = (count == '0);

endmodule
`default_nettype wire

// ----- src/bed_back.sv -----
`default_nettype none
module bed_back
  import bed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire bundle_t    q_data,
  output logic            pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic [2:0]      m_tuser,
  output logic            m_tlast
);

  bundle_t    cur;
  logic [1:0] idx;
  logic       busy;
  logic       last_res;
  logic       xfer;
  logic       done;
  res_t       r;

  assign last_res = (idx == cur.cnt - 2'd1);
  assign xfer     = busy && m_tready;
  assign done     = xfer && last_res;
  assign pop      = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (xfer) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_comb begin
    unique case (idx)
      2'd0:    r = cur.res[0];
      2'd1:    r = cur.res[1];
      2'd2:    r = cur.res[2];
      default: r = cur.res[0];
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = r.byte_val;
  assign m_tuser  = {r.stop, r.miss, r.has_byte};
  assign m_tlast  = last_res;

endmodule
`default_nettype wire

// ----- src/backslash_escape_decoder_top.sv -----
// Backslash escape decoder.
// Input stream: one character per transfer on s_tdata, s_tlast marks the final
// character of a string, s_tuser marks the first character of a new call.
// Output stream: one decoded result per transfer; an input character causes
// zero to three results and m_tlast marks the last one it caused.
// m_tuser flags a result as carrying a byte, a \x with no hex digits, or the
// status-only result of a \c stop.
// Throughput: one input transfer per cycle while the bundle queue has room; the
// output side moves one result per cycle while results wait and m_tready is high.
// Path: a character is decoded combinationally into a bundle that the bundle
// queue registers; the back end then registers the bundle out onto m_tvalid.
// The front decoder and the result serializer are split by a two-entry bundle
// queue; s_tready drops only when that queue is full.
// If the receiver stalls, results hold steady and input keeps flowing until
// the queue fills.
// Reset (rst, synchronous) returns the decoder to idle, clears a stop, empties
// the queue and sets argument_mode to 1.
// APB register at byte 0: argument_mode (bit 0). Write only while idle.
`default_nettype none
module backslash_escape_decoder_top
  import bed_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] in_byte
  input  wire logic        s_tlast,  // is_last
  input  wire logic        s_tuser,  // [0] new_call
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // [7:0] out_byte
  output logic             m_tlast,  // run_last
  output logic [2:0]       m_tuser,  // [0] has_byte, [1] missing_hex_digit, [2] stopped
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic    argument_mode;
  logic    cfg_wr;
  logic    accept;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  bundle_t fr_bundle;
  bundle_t q_data;

  // register 0 lives at byte 0; paddr[2] selects the register word
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      argument_mode <= 1'b1;
    end else if (cfg_wr && !paddr[2]) begin
      argument_mode <= pwdata[0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {31'd0, argument_mode};

  // a transfer is taken whenever the bundle queue has room
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  bed_front u_front (
    .clk           (clk),
    .rst           (rst),
    .argument_mode (argument_mode),
    .accept        (accept),
    .in_byte       (s_tdata),
    .is_last       (s_tlast),
    .new_call      (s_tuser),
    .bundle        (fr_bundle),
    .push          (push)
  );

  bed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (fr_bundle),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  bed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- dv/escape_decode_checker.sv -----
// Watches both streams and the register port, predicts every decoded result
// and compares it field by field, oldest first.
module escape_decode_checker
  import bed_pkg::*;
#(
  parameter logic [2:0] MODE_ADDR = 3'd0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] in_byte
  input  wire logic        s_tlast,  // is_last
  input  wire logic        s_tuser,  // [0] new_call
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [7:0]  m_tdata,  // [7:0] out_byte
  input  wire logic        m_tlast,  // run_last
  input  wire logic [2:0]  m_tuser,  // [0] has_byte, [1] missing_hex_digit, [2] stopped
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatches,
  output int               results_owed,
  output int               chars_decoded
);

  localparam logic [7:0] CH_SEVEN = 8'h37;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       miss;
    logic       stop;
  } dec_out_t;

  dec_out_t   owed_q[$];    // decoded results not yet seen on the output
  dec_out_t   char_out[$];  // results of the character being decoded

  phase_t     ph;
  logic [8:0] acc;
  logic [1:0] ndig;
  logic       halted;
  logic       arg_mode;

  function automatic void emit(input logic [7:0] ch, input logic has, input logic miss,
                               input logic stop);
    dec_out_t r;
    r.ch   = ch;
    r.has  = has;
    r.last = 1'b0;
    r.miss = miss;
    r.stop = stop;
    if (char_out.size() < MAX_RES) begin
      char_out.push_back(r);
    end
  endfunction

  function automatic void to_idle();
    ph   = PH_IDLE;
    acc  = '0;
    ndig = '0;
  endfunction

  function automatic void take_plain(input logic [7:0] b);
    if (b == CH_BS) begin
      ph = PH_ESC;
    end else begin
      emit(b, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  // {hit, code}
  function automatic logic [8:0] letter_code(input logic [7:0] b);
    case (b)
      8'h6E:        return {1'b1, 8'h0A};  // n
      8'h74:        return {1'b1, 8'h09};  // t
      8'h72:        return {1'b1, 8'h0D};  // r
      CH_BS:        return {1'b1, CH_BS};
      8'h61:        return {1'b1, 8'h07};  // a
      8'h62:        return {1'b1, 8'h08};  // b
      8'h66:        return {1'b1, 8'h0C};  // f
      8'h76:        return {1'b1, 8'h0B};  // v
      8'h65, 8'h45: return {1'b1, CH_ESC}; // e, E
      default:      return 9'h000;
    endcase
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) begin
      return {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      return {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      return {1'b1, 4'(b - 8'h37)};
    end
    return 5'h00;
  endfunction

  function automatic void after_backslash(input logic [7:0] b);
    logic [8:0] lc;
    lc = letter_code(b);
    if (lc[8]) begin
      emit(lc[7:0], 1'b1, 1'b0, 1'b0);
      to_idle();
    end else if (b == CH_C && arg_mode) begin
      halted = 1'b1;
      emit(8'h00, 1'b0, 1'b0, 1'b1);
      to_idle();
    end else if (b == CH_X) begin
      ph   = PH_HEX;
      acc  = '0;
      ndig = '0;
    end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
      ph = PH_OCT;
      if (arg_mode && b == CH_ZERO) begin
        // leading zero is only a marker here
        acc  = '0;
        ndig = 2'd0;
      end else begin
        acc  = {6'd0, b[2:0]};
        ndig = 2'd1;
      end
    end else begin
      emit(CH_BS, 1'b1, 1'b0, 1'b0);
      to_idle();
      take_plain(b);
    end
  endfunction

  function automatic void flush_escape();
    case (ph)
      PH_ESC: emit(CH_BS, 1'b1, 1'b0, 1'b0);
      PH_HEX: begin
        if (ndig == 2'd0) begin
          emit(CH_BS, 1'b1, 1'b1, 1'b0);
          emit(CH_X, 1'b1, 1'b0, 1'b0);
        end else begin
          emit(acc[7:0], 1'b1, 1'b0, 1'b0);
        end
      end
      PH_OCT: emit(acc[7:0], 1'b1, 1'b0, 1'b0);
      default: ;
    endcase
    to_idle();
  endfunction

  function automatic void decode_char(input logic [7:0] b, input logic last,
                                      input logic fresh);
    logic [4:0] hv;
    char_out.delete();
    if (fresh) begin
      halted = 1'b0;
      to_idle();
    end
    if (halted) begin
      return;
    end
    chars_decoded++;
    hv = hex_val(b);
    case (ph)
      PH_IDLE: take_plain(b);
      PH_ESC:  after_backslash(b);
      PH_HEX: begin
        if (hv[4]) begin
          acc  = {acc[4:0], hv[3:0]};
          ndig = ndig + 2'd1;
          if (ndig >= 2'd2) begin
            emit(acc[7:0], 1'b1, 1'b0, 1'b0);
            to_idle();
          end
        end else begin
          flush_escape();
          take_plain(b);
        end
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_SEVEN && ndig < 2'd3) begin
          acc  = {acc[5:0], b[2:0]};
          ndig = ndig + 2'd1;
          if (ndig >= 2'd3) begin
            emit(acc[7:0], 1'b1, 1'b0, 1'b0);
            to_idle();
          end
        end else begin
          flush_escape();
          take_plain(b);
        end
      end
    endcase
    if (last && !halted) begin
      flush_escape();
    end
    if (char_out.size() != 0) begin
      char_out[char_out.size() - 1].last = 1'b1;
    end
    foreach (char_out[i]) begin
      owed_q.push_back(char_out[i]);
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    dec_out_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing expected: out_byte %02h tuser %b", m_tdata, m_tuser);
      mismatches++;
      return;
    end
    want = owed_q.pop_front();
    cmp_field("out_byte", want.ch, m_tdata);
    cmp_field("has_byte", {7'd0, want.has}, {7'd0, m_tuser[0]});
    cmp_field("missing_hex_digit", {7'd0, want.miss}, {7'd0, m_tuser[1]});
    cmp_field("stopped", {7'd0, want.stop}, {7'd0, m_tuser[2]});
    cmp_field("run_last", {7'd0, want.last}, {7'd0, m_tlast});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      to_idle();
      halted        = 1'b0;
      arg_mode      = 1'b1;
      mismatches    = 0;
      chars_decoded = 0;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        arg_mode = pwdata[0];
      end
      if (s_tvalid && s_tready) begin
        decode_char(s_tdata, s_tlast, s_tuser);
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ----- dv/backslash_escape_decoder_top_test.sv -----
// Stimulus and verdict for the backslash escape decoder. The checker beside
// the block predicts and compares; this module drives traffic and reports.
module backslash_escape_decoder_top_test;
  import bed_pkg::*;

  localparam logic [2:0] REG_ARG_MODE = 3'd0;  // argument_mode register
  localparam int         SINK_HOLD    = 300;   // long receiver stall, cycles
  localparam int         DRAIN_WAIT   = 6;     // settle time past last result
  localparam int         PHASE_CHARS  = 80;    // decoded chars per random phase

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;

  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [7:0]  m_tdata;
  wire logic        m_tlast;
  wire logic [2:0]  m_tuser;
  wire logic [31:0] prdata;
  wire logic        pready;

  int mismatches;
  int results_owed;
  int chars_decoded;

  // Idling controls: quiet stretches run with no gaps on that side
  logic src_quiet     = 1'b0;
  logic calm_phase    = 1'b0;
  logic sink_quiet    = 1'b0;
  logic sink_hold_req = 1'b0;

  logic [7:0] run_txt[$];  // one generated string
  string esc_letters = "ntr\\abfveE";
  string hex_chars   = "0123456789abcdefABCDEF";

  backslash_escape_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  escape_decode_checker #(
    .MODE_ADDR (REG_ARG_MODE)
  ) u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .results_owed  (results_owed),
    .chars_decoded (chars_decoded)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; a run that reaches it is reported as failed
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // One input transfer, after a random gap unless the sender is quiet.
  // Valid stays high when the next char follows with no gap.
  task automatic send_char(input logic [7:0] b, input logic last, input logic fresh);
    int gap;
    gap = (src_quiet || calm_phase) ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= fresh;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // new_call on the first char if fresh, is_last on the final one if closed
  task automatic send_text(input string txt, input bit fresh, input bit closed);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i], closed && i == txt.len() - 1, fresh && i == 0);
    end
  endtask

  // Sender pauses until every predicted result is out, then lets the
  // pipeline settle (a char swallowed by a stop yields nothing to wait on)
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; register updates at the access edge
  task automatic write_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ARG_MODE;
    pwdata  <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    return (c == CH_BS) ? 8'h71 : c;
  endfunction

  // Append one token: a plain char or a backslash escape with random content
  function automatic void add_token();
    int pick;
    int ndig;
    bit marker;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      run_txt.push_back(plain_char());
    end else begin
      run_txt.push_back(CH_BS);
      if (pick < 45) begin
        run_txt.push_back(esc_letters[$urandom_range(9, 0)]);
      end else if (pick < 60) begin
        // zero digits gives the missing-digit case
        run_txt.push_back(CH_X);
        repeat ($urandom_range(2, 0)) run_txt.push_back(hex_chars[$urandom_range(21, 0)]);
      end else if (pick < 80) begin
        marker = $urandom_range(1, 0);
        if (marker) begin
          run_txt.push_back(CH_ZERO);
        end
        ndig = $urandom_range(3, marker ? 0 : 1);
        repeat (ndig) run_txt.push_back(CH_ZERO + 8'($urandom_range(7, 0)));
      end else if (pick < 85) begin
        run_txt.push_back(CH_C);
      end else if (pick < 95) begin
        run_txt.push_back(plain_char());
      end
      // otherwise a lone backslash, ended by whatever follows
    end
  endfunction

  // A string of tokens: mostly opened with new_call and closed with is_last
  task automatic random_run();
    bit fresh;
    bit closed;
    run_txt.delete();
    repeat ($urandom_range(6, 1)) add_token();
    fresh     = $urandom_range(3, 0) != 0;
    closed    = $urandom_range(7, 0) != 0;
    src_quiet = $urandom_range(3, 0) == 0;
    foreach (run_txt[i]) begin
      send_char(run_txt[i], closed && i == run_txt.size() - 1, fresh && i == 0);
    end
  endtask

  // Settle, set the mode, then mixed strings and raw noise
  task automatic random_phase(input logic mode, input bit hold_sink, input bit calm);
    int goal;
    drain();
    write_mode(mode);
    calm_phase    = calm;
    sink_hold_req = hold_sink;
    goal = chars_decoded + PHASE_CHARS;
    while (chars_decoded < goal) begin
      if ($urandom_range(6, 0) == 0) begin
        send_char(8'($urandom_range(255, 1)), $urandom_range(3, 0) == 0,
                  $urandom_range(7, 0) == 0);
      end else begin
        random_run();
      end
    end
    calm_phase = 1'b0;
  endtask

  // Receiver: random backpressure per result, quiet stretches, and one long
  // hold-off on request so the bundle queue fills and s_tready drops
  initial begin : sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      if ($urandom_range(15, 0) == 0) begin
        sink_quiet = !sink_quiet;
      end
      gap = sink_quiet ? 0 : $urandom_range(7, 0);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b1);

    // Argument mode: letter escape, two-digit hex, \x with no digits
    send_text("\\e\\xaF\\xz", 1'b1, 1'b0);
    // \0 marker with three digits, marker alone ended by a backslash,
    // octal value past 8 bits
    send_text("\\0101\\0\\777", 1'b0, 1'b0);
    // \c stops output; the next char is swallowed
    send_text("\\cq", 1'b0, 1'b1);
    // new call clears the stop; unknown escape, trailing backslash
    send_text("\\q\\", 1'b1, 1'b1);
    // NUL is an ordinary char
    send_char(8'h00, 1'b1, 1'b0);

    random_phase(1'b0, 1'b0, 1'b0);
    random_phase(1'b1, 1'b1, 1'b0);  // long receiver stall
    random_phase(1'b0, 1'b0, 1'b1);  // sender never idles
    random_phase(1'b1, 1'b0, 1'b0);
    random_phase(1'b0, 1'b1, 1'b0);
    random_phase(1'b1, 1'b0, 1'b0);

    drain();
    @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bed_pkg.sv
src/bed_front.sv
src/bed_queue.sv
src/bed_back.sv
src/backslash_escape_decoder_top.sv
dv/escape_decode_checker.sv
dv/backslash_escape_decoder_top_test.sv
